@@ src/lpdpm_pkg.sv @@
package lpdpm_pkg;

	localparam int ProfileDepth = 2048;
	localparam int AddrW = 11;
	localparam int CountW = 12;
	localparam int MaxAverage = 16;

	localparam logic [1:0] RegAvg = 2'd0;
	localparam logic [1:0] RegPix = 2'd1;
	localparam logic [1:0] RegRuler = 2'd2;

	typedef enum logic [3:0] {
		ST_LOAD, ST_MEAN, ST_PREP, ST_SCAN, ST_CDIV, ST_CDONE,
		ST_PDIV, ST_ZMUL, ST_ZDIV, ST_OUT
	} state_t;

	// restoring divider control
	typedef struct packed {
		logic        start;
		logic [47:0] num;
		logic [47:0] den;
	} div_req_t;

	// clamp average_count to the usable range
	function automatic logic [4:0] eff_avg(input logic [4:0] a);
		logic [4:0] r;
		r = a;
		if (r == 5'd0) r = 5'd1;
		if (r > 5'(MaxAverage)) r = 5'(MaxAverage);
		return r;
	endfunction

	// ceil(2^24 / a): multiply and keep bits from 24 up for an exact floor
	// division by a of any dividend below 2^20
	function automatic logic [24:0] recip_avg(input logic [4:0] a);
		logic [24:0] r;
		unique case (a)
			5'd2:    r = 25'd8388608;
			5'd3:    r = 25'd5592406;
			5'd4:    r = 25'd4194304;
			5'd5:    r = 25'd3355444;
			5'd6:    r = 25'd2796203;
			5'd7:    r = 25'd2396746;
			5'd8:    r = 25'd2097152;
			5'd9:    r = 25'd1864136;
			5'd10:   r = 25'd1677722;
			5'd11:   r = 25'd1525202;
			5'd12:   r = 25'd1398102;
			5'd13:   r = 25'd1290556;
			5'd14:   r = 25'd1198373;
			5'd15:   r = 25'd1118482;
			5'd16:   r = 25'd1048576;
			default: r = 25'd16777216;
		endcase
		return r;
	endfunction

endpackage

@@ src/line_profile_dip_period_meter_core.sv @@
// channel | direction | signals
// config  | in/out    | psel penable pwrite paddr pwdata prdata pready
// sample  | in        | start busy strip_sum last_sample
// result  | out       | done sample_count mean_q8 dip_count period_q8 zoom_q16 result_valid overflowed
// a word without last_sample is taken whenever busy is low; busy stays low
// a final word holds busy through the mean division, a pass over the stored samples
// with a division per closed dip centroid, then, with a period, the period division
// and, at a nonzero ruler pitch, the zoom division
// done pulses once as busy falls; the receiver cannot stall
// arst_n clears control, registers and totals; the store is not cleared
module line_profile_dip_period_meter_core
	import lpdpm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [11:0] strip_sum,
	input  logic        last_sample,
	output logic        done,
	output logic [11:0] sample_count,
	output logic [15:0] mean_q8,
	output logic [10:0] dip_count,
	output logic [18:0] period_q8,
	output logic [31:0] zoom_q16,
	output logic        result_valid,
	output logic        overflowed
);

	logic [4:0]  avg_q;
	logic [15:0] pix_q;
	logic [15:0] ruler_q;
	logic [1:0]  reg_idx;
	logic        wr;

	assign reg_idx = paddr[3:2];
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= 5'd3;
			pix_q <= 16'd530;
			ruler_q <= 16'd50000;
		end else if (wr && paddr[1:0] == 2'b00) begin
			unique case (reg_idx)
				RegAvg:   avg_q <= pwdata[4:0];
				RegPix:   pix_q <= pwdata[15:0];
				RegRuler: ruler_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			RegAvg:   prdata = {27'd0, avg_q};
			RegPix:   prdata = {16'd0, pix_q};
			RegRuler: prdata = {16'd0, ruler_q};
			default:  prdata = '0;
		endcase
	end

	state_t      state_q, state_d;
	logic [CountW-1:0] cnt_q;
	logic [18:0] total_q;
	logic        ovf_q;
	logic [CountW-1:0] idx_q;
	logic [AddrW-1:0]  idx_s1;
	logic        vld_s1;
	logic [AddrW-1:0]  idx_s2;
	logic [19:0] vq8_s2;
	logic        vld_s2;
	logic [15:0] mean_q;
	logic [26:0] wsum_q;
	logic [37:0] msum_q;
	logic [18:0] first_q, last_q;
	logic [10:0] dips_q;
	logic        seen_q;
	logic [18:0] per_q;
	logic [47:0] prod_q;
	logic [11:0] rdata;
	logic        div_busy;
	logic [47:0] quot;
	div_req_t    dreq;
	logic        accept;
	logic        store_ok;
	logic [4:0]  a;
	logic [24:0] recip;
	logic [44:0] ia_prod;
	logic [44:0] vq8_prod;
	logic [11:0] ia_raw;
	logic [7:0]  ia;
	logic [19:0] vq8;
	logic [19:0] w;

	assign accept = start && !busy;
	assign busy = (state_q != ST_LOAD);
	assign a = eff_avg(avg_q);
	assign recip = recip_avg(a);
	assign store_ok = (cnt_q < CountW'(ProfileDepth));

	// integer average by reciprocal multiplication
	assign ia_prod = {33'd0, strip_sum} * {20'd0, recip};
	assign ia_raw = ia_prod[35:24];
	assign ia = (ia_raw > 12'd255) ? 8'd255 : ia_raw[7:0];

	lpdpm_store u_store (
		.clk  (clk),
		.we   (accept && store_ok),
		.waddr(cnt_q[AddrW-1:0]),
		.wdata(strip_sum),
		.raddr(idx_q[AddrW-1:0]),
		.rdata(rdata)
	);

	lpdpm_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (dreq),
		.busy  (div_busy),
		.quot  (quot)
	);

	// exact Q8 average of the stored sample, registered before use
	assign vq8_prod = {25'd0, rdata, 8'd0} * {20'd0, recip};
	assign vq8 = vq8_prod[43:24];
	assign w = {4'd0, mean_q} - vq8_s2;

	always_comb begin
		state_d = state_q;
		dreq = '0;
		unique case (state_q)
			ST_LOAD: if (accept && last_sample) begin
				state_d = ST_MEAN;
			end
			ST_MEAN: begin
				dreq.start = 1'b1;
				dreq.num = {21'd0, total_q, 8'd0};
				dreq.den = {36'd0, cnt_q};
				state_d = ST_PREP;
			end
			ST_PREP: if (!div_busy) state_d = ST_SCAN;
			ST_SCAN: if (vld_s2 && vq8_s2 >= {4'd0, mean_q} && wsum_q != 27'd0) begin
				dreq.start = 1'b1;
				dreq.num = {2'd0, msum_q, 8'd0};
				dreq.den = {21'd0, wsum_q};
				state_d = ST_CDIV;
			end else if (!vld_s1 && !vld_s2 && idx_q >= cnt_q) begin
				state_d = ST_PDIV;
			end
			ST_CDIV: if (!div_busy) state_d = ST_CDONE;
			ST_CDONE: state_d = ST_SCAN;
			ST_PDIV: begin
				if (dips_q >= 11'd2) begin
					dreq.start = 1'b1;
					dreq.num = (last_q >= first_q) ? {29'd0, last_q - first_q} : '0;
					dreq.den = {37'd0, dips_q - 11'd1};
					state_d = ST_ZMUL;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_ZMUL: if (!div_busy) state_d = ST_ZDIV;
			ST_ZDIV: begin
				if (prod_q[47] == 1'b0 && ruler_q != 16'd0) begin
					dreq.start = 1'b1;
					dreq.num = prod_q;
					dreq.den = {32'd0, ruler_q};
				end
				state_d = ST_OUT;
			end
			ST_OUT: if (!div_busy) state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath and measurement state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; total_q <= '0; ovf_q <= 1'b0; idx_q <= '0; vld_s1 <= 1'b0;
			wsum_q <= '0; msum_q <= '0; first_q <= '0; last_q <= '0;
			dips_q <= '0; seen_q <= 1'b0; done <= 1'b0; mean_q <= '0; per_q <= '0;
			prod_q <= '0; idx_s1 <= '0; idx_s2 <= '0; vq8_s2 <= '0; vld_s2 <= 1'b0;
			sample_count <= '0; mean_q8 <= '0; dip_count <= '0; period_q8 <= '0;
			zoom_q16 <= '0; result_valid <= 1'b0; overflowed <= 1'b0;
		end else begin
			done <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			unique case (state_q)
				ST_LOAD: if (accept) begin
					if (store_ok) begin
						cnt_q <= cnt_q + 1'b1;
						total_q <= total_q + {11'd0, ia};
					end else begin
						ovf_q <= 1'b1;
					end
				end
				ST_PREP: begin
					idx_q <= '0;
					if (!div_busy) mean_q <= (cnt_q == '0) ? 16'd0 : quot[15:0];
				end
				ST_SCAN: begin
					if (vld_s2) begin
						if (vq8_s2 < {4'd0, mean_q}) begin
							if (seen_q) begin
								wsum_q <= wsum_q + {7'd0, w};
								msum_q <= msum_q + {18'd0, w} * {27'd0, idx_s2};
							end
						end else begin
							seen_q <= 1'b1;
							if (wsum_q == 27'd0) begin
								msum_q <= '0;
							end
						end
					end else if (vld_s1) begin
						vq8_s2 <= vq8;
						idx_s2 <= idx_s1;
						vld_s2 <= 1'b1;
					end else if (idx_q < cnt_q) begin
						idx_s1 <= idx_q[AddrW-1:0];
						idx_q <= idx_q + 1'b1;
						vld_s1 <= 1'b1;
					end
				end
				ST_CDONE: begin
					if (dips_q == 11'd0) first_q <= quot[18:0];
					last_q <= quot[18:0];
					dips_q <= dips_q + 1'b1;
					wsum_q <= '0;
					msum_q <= '0;
				end
				ST_PDIV: per_q <= '0;
				ST_ZMUL: if (!div_busy) begin
					per_q <= quot[18:0];
					prod_q <= {29'd0, quot[18:0]} * {32'd0, pix_q} * 48'd256;
				end
				ST_OUT: if (!div_busy) begin
					done <= 1'b1;
					sample_count <= cnt_q;
					mean_q8 <= mean_q;
					dip_count <= dips_q;
					result_valid <= (dips_q >= 11'd2);
					overflowed <= ovf_q;
					period_q8 <= per_q;
					if (dips_q < 11'd2) zoom_q16 <= '0;
					else if (ruler_q == 16'd0 || prod_q[47] || quot[47:32] != 16'd0)
						zoom_q16 <= 32'hFFFF_FFFF;
					else zoom_q16 <= quot[31:0];
					cnt_q <= '0; total_q <= '0; ovf_q <= 1'b0; wsum_q <= '0;
					msum_q <= '0; first_q <= '0; last_q <= '0; dips_q <= '0;
					seen_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// done only leaves the computation path
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without busy");
	// valid means at least two dips
	a_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result_valid) |-> dip_count >= 11'd2) else $error("valid dips");
	// no word taken while busy
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> $stable(total_q) || done) else $error("total moved while busy");

endmodule

@@ src/lpdpm_div.sv @@
module lpdpm_div
	import lpdpm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  div_req_t    req,
	output logic        busy,
	output logic [47:0] quot
);

	logic [47:0] rem_q;
	logic [47:0] quo_q;
	logic [47:0] den_q;
	logic [5:0]  cnt_q;
	logic [48:0] trial;

	assign trial = {rem_q, quo_q[47]} - {1'b0, den_q};

	// one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= 6'd48;
		end else if (cnt_q != 6'd0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (cnt_q != 6'd0) begin
			if (!trial[48]) begin
				rem_q <= trial[47:0];
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= {rem_q[46:0], quo_q[47]};
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != 6'd0);
	assign quot = quo_q;

endmodule

@@ src/lpdpm_store.sv @@
module lpdpm_store
	import lpdpm_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [AddrW-1:0]  waddr,
	input  logic [11:0]       wdata,
	input  logic [AddrW-1:0]  raddr,
	output logic [11:0]       rdata
);

	logic [11:0] mem [ProfileDepth];

	// single port write, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ dv/line_profile_dip_period_meter_checker.sv @@
`timescale 1ns / 100ps

module line_profile_dip_period_meter_checker
	import lpdpm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        start,
	input  logic        busy,
	input  logic [11:0] strip_sum,
	input  logic        last_sample,
	input  logic        done,
	input  logic [11:0] sample_count,
	input  logic [15:0] mean_q8,
	input  logic [10:0] dip_count,
	input  logic [18:0] period_q8,
	input  logic [31:0] zoom_q16,
	input  logic        result_valid,
	input  logic        overflowed,
	output int          mismatches,
	output int          pending,
	output int          measurements,
	output int          valid_seen,
	output int          overflow_runs
);

	typedef struct {
		logic [11:0] count;
		logic [15:0] mean;
		logic [10:0] dips;
		logic [18:0] period;
		logic [31:0] zoom;
		logic        valid;
		logic        ovf;
	} measurement_t;

	measurement_t expected_q[$];

	// shadow registers
	logic [4:0]  avg_reg;
	logic [15:0] pix_reg;
	logic [15:0] ruler_reg;

	// shadow of the profile being loaded
	logic [11:0] profile[ProfileDepth];
	int unsigned n_stored;
	longint unsigned int_total;
	bit          ovf_flag;

	function automatic int unsigned clamp_avg(input logic [4:0] a);
		int unsigned r;
		r = a;
		if (r == 0) r = 1;
		if (r > MaxAverage) r = MaxAverage;
		return r;
	endfunction

	// second pass over the stored profile: mean, dip centroids, period, zoom
	function automatic measurement_t measure_profile();
		measurement_t m;
		int unsigned a;
		longint unsigned mean, v, w, wsum, msum, c, first_c, last_c, span, per, zm;
		int unsigned ndips;
		bit above;
		a = clamp_avg(avg_reg);
		mean = n_stored ? (int_total * 256) / n_stored : 0;
		wsum = 0; msum = 0; first_c = 0; last_c = 0; ndips = 0; above = 0;
		per = 0; zm = 0;
		for (int i = 0; i < n_stored; i++) begin
			v = (longint'(profile[i]) * 256) / a;
			if (v < mean) begin
				if (above) begin
					w = mean - v;
					wsum += w;
					msum += w * i;
				end
			end else begin
				above = 1;
				if (wsum != 0) begin
					c = (msum * 256) / wsum;
					if (ndips == 0) first_c = c;
					last_c = c;
					ndips++;
				end
				wsum = 0;
				msum = 0;
			end
		end
		if (ndips >= 2) begin
			span = (last_c >= first_c) ? last_c - first_c : 0;
			per = span / (ndips - 1);
			if (ruler_reg == 0) zm = 64'hFFFF_FFFF;
			else begin
				zm = (per * pix_reg * 256) / ruler_reg;
				if (zm > 64'hFFFF_FFFF) zm = 64'hFFFF_FFFF;
			end
		end
		m.count = n_stored[11:0];
		m.mean = mean[15:0];
		m.dips = ndips[10:0];
		m.period = per[18:0];
		m.zoom = zm[31:0];
		m.valid = (ndips >= 2);
		m.ovf = ovf_flag;
		return m;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		measurement_t e;
		int unsigned ia;
		if (!arst_n) begin
			avg_reg <= 5'd3;
			pix_reg <= 16'd530;
			ruler_reg <= 16'd50000;
			n_stored = 0;
			int_total = 0;
			ovf_flag = 0;
			expected_q.delete();
			mismatches <= 0;
			measurements <= 0;
			valid_seen <= 0;
			overflow_runs <= 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					RegAvg: avg_reg <= pwdata[4:0];
					RegPix: pix_reg <= pwdata[15:0];
					RegRuler: ruler_reg <= pwdata[15:0];
					default: ;
				endcase
			end
			// accepted sample word
			if (start && !busy) begin
				if (n_stored < ProfileDepth) begin
					ia = strip_sum / clamp_avg(avg_reg);
					if (ia > 255) ia = 255;
					profile[n_stored] = strip_sum;
					n_stored++;
					int_total += ia;
				end else begin
					ovf_flag = 1;
				end
				if (last_sample) begin
					e = measure_profile();
					expected_q.push_back(e);
					if (e.valid) valid_seen <= valid_seen + 1;
					if (e.ovf) overflow_runs <= overflow_runs + 1;
					n_stored = 0;
					int_total = 0;
					ovf_flag = 0;
				end
			end
			// result word against the oldest expectation
			if (done) begin
				measurements <= measurements + 1;
				if (expected_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected result word, count %0d", $time, sample_count);
					mismatches <= mismatches + 1;
				end else begin
					e = expected_q.pop_front();
					if (e.count !== sample_count || e.mean !== mean_q8 ||
							e.dips !== dip_count || e.period !== period_q8 ||
							e.zoom !== zoom_q16 || e.valid !== result_valid ||
							e.ovf !== overflowed) begin
						if (mismatches < 10) begin
							$display("%0t: mismatch exp cnt %0d mean %0d dips %0d per %0d zoom %0h v %0d o %0d",
								$time, e.count, e.mean, e.dips, e.period, e.zoom, e.valid, e.ovf);
							$display("          got cnt %0d mean %0d dips %0d per %0d zoom %0h v %0d o %0d",
								sample_count, mean_q8, dip_count, period_q8, zoom_q16,
								result_valid, overflowed);
						end
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

endmodule

@@ dv/line_profile_dip_period_meter_core_tb.sv @@
`timescale 1ns / 100ps

module line_profile_dip_period_meter_core_tb;
	import lpdpm_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        start, busy;
	logic [11:0] strip_sum;
	logic        last_sample;
	logic        done;
	logic [11:0] sample_count;
	logic [15:0] mean_q8;
	logic [10:0] dip_count;
	logic [18:0] period_q8;
	logic [31:0] zoom_q16;
	logic        result_valid, overflowed;
	int          mismatches, pending, measurements, valid_seen, overflow_runs;
	int          words_sent;
	bit          no_gaps;

	line_profile_dip_period_meter_core i_dut (.*);

	line_profile_dip_period_meter_checker i_checker (.*);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// overall time limit
	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (no_gaps || r < 10) return 0;
		if (r < 18) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// present one sample word and hold it until taken
	task automatic send_word(input logic [11:0] s, input logic last);
		int unsigned g;
		start <= 1'b1;
		strip_sum <= s;
		last_sample <= last;
		do @(posedge clk); while (busy);
		words_sent++;
		g = pick_gap();
		if (g != 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// stop sending and let every result word arrive
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(input logic [4:0] a, input logic [15:0] pix, input logic [15:0] rul);
		drain();
		write_reg(RegAvg, {27'd0, a});
		write_reg(RegPix, {16'd0, pix});
		write_reg(RegRuler, {16'd0, rul});
	endtask

	// profile of ruler graduations: low dips on a bright background plus noise
	task automatic graduated_profile(input int len);
		int unsigned per, width, phase, hi, lo, noise, v;
		per = $urandom_range(3, 40);
		width = $urandom_range(1, per - 1);
		phase = $urandom_range(0, per - 1);
		hi = $urandom_range(200, 4080);
		lo = $urandom_range(0, hi - 100);
		noise = $urandom_range(0, 40);
		for (int i = 0; i < len; i++) begin
			v = (((i + phase) % per) < width) ? lo : hi;
			v = v + $urandom_range(0, noise);
			if (v > 4080) v = 4080;
			send_word(v[11:0], i == len - 1);
		end
	endtask

	task automatic noise_profile(input int len);
		for (int i = 0; i < len; i++)
			send_word(12'($urandom_range(0, 4080)), i == len - 1);
	endtask

	task automatic random_profile();
		int unsigned k;
		no_gaps = ($urandom_range(0, 4) == 0);
		k = $urandom_range(0, 9);
		if (k < 7) graduated_profile($urandom_range(2, 60));
		else if (k < 9) noise_profile($urandom_range(1, 30));
		else graduated_profile(1);
		no_gaps = 0;
		if ($urandom_range(0, 7) == 0) drain();
	endtask

	task automatic run_phase(input int words);
		int target;
		target = words_sent + words;
		while (words_sent < target) random_profile();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		start = 1'b0; strip_sum = '0; last_sample = 1'b0;
		words_sent = 0;
		no_gaps = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single-sample extremes, a dip before the first bright sample,
		// an open final dip, and a flat profile
		send_word(12'd0, 1'b1);
		send_word(12'd4080, 1'b1);
		send_word(12'd10, 1'b0);
		send_word(12'd900, 1'b0);
		send_word(12'd10, 1'b0);
		send_word(12'd900, 1'b0);
		send_word(12'd30, 1'b0);
		send_word(12'd900, 1'b0);
		send_word(12'd5, 1'b1);
		send_word(12'd77, 1'b0);
		send_word(12'd77, 1'b1);
		// saturating integer average and zoom, with the sender held off
		set_regs(5'd0, 16'hFFFF, 16'd1);
		send_word(12'd4080, 1'b0);
		send_word(12'd0, 1'b0);
		send_word(12'd4080, 1'b0);
		send_word(12'd0, 1'b0);
		send_word(12'd4080, 1'b0);
		send_word(12'd0, 1'b0);
		send_word(12'd4080, 1'b1);
		// zero ruler pitch with a valid result
		set_regs(5'd31, 16'd1, 16'd0);
		send_word(12'd4080, 1'b0);
		send_word(12'd1000, 1'b0);
		send_word(12'd4080, 1'b0);
		send_word(12'd2000, 1'b0);
		send_word(12'd4080, 1'b1);

		// random phases across register settings
		set_regs(5'd3, 16'd530, 16'd50000);
		run_phase(150);
		set_regs(5'd1, 16'hFFFF, 16'd1);
		run_phase(120);
		set_regs(5'd16, 16'd1, 16'hFFFF);
		run_phase(120);
		set_regs(5'd0, 16'($urandom_range(1, 65535)), 16'd0);
		run_phase(80);
		for (int p = 0; p < 3; p++) begin
			set_regs(5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)));
			run_phase(110);
		end

		drain();
		repeat (200) @(posedge clk);
		$display("sent %0d sample words, %0d measurements checked", words_sent, measurements);
		$display("%0d with a valid period, %0d with a dropped-sample overflow",
			valid_seen, overflow_runs);
		if (mismatches == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

@@ line_profile_dip_period_meter_core.f @@
src/lpdpm_pkg.sv
src/lpdpm_div.sv
src/lpdpm_store.sv
src/line_profile_dip_period_meter_core.sv
dv/line_profile_dip_period_meter_checker.sv
dv/line_profile_dip_period_meter_core_tb.sv
